FILE: sv/ncs_pkg.sv
// Shared types, constants and helpers for the natural cubic spline fitter
`default_nettype none

package ncs_pkg;

  // Data word width of knots, sweep values, slopes and coefficients
  localparam int WORD_W = 32;
  // Entries in the gamma tables; the recurrence settles well before the end
  localparam int GTAB_N = 32;
  localparam int GIDX_W = 5;

  typedef logic [WORD_W-1:0] gword_t;
  typedef gword_t gtab_t [GTAB_N];

  // Commands from the controller to the datapath
  typedef struct packed {
    logic load;     // store the offered knot word
    logic close;    // run closes: latch segment count, clear knot count
    logic idx_clr;
    logic idx_inc;
    logic idx_dec;
    logic sw_rd_l;  // sweep: read left knot
    logic sw_rd_r;  // sweep: read right knot, capture left
    logic sw_diff;  // sweep: form 3*diff - previous delta
    logic sw_mul;   // sweep: multiply by gamma
    logic sw_wr;    // sweep: round, saturate, store delta
    logic bk_init;  // back substitution: seed the last slope
    logic bk_mul;   // back substitution: read delta, multiply slope by gamma
    logic bk_wr;    // back substitution: store slope
    logic em_ld;    // emit: capture first knot and slope
    logic em_out;   // emit: present one segment
  } ncs_cmd_t;

  // Status back to the controller
  typedef struct packed {
    logic cnt_nonzero;
    logic idx_zero;
    logic idx_at_n;
    logic idx_at_seg_end;
  } ncs_sts_t;

  // Saturate a wide signed value to one data word
  function automatic logic signed [WORD_W-1:0] sat_word(input logic signed [63:0] v);
    logic signed [63:0] hi;
    logic signed [63:0] lo;
    hi = 64'sd2147483647;
    lo = -64'sd2147483648;
    if (v > hi) begin
      sat_word = hi[WORD_W-1:0];
    end else if (v < lo) begin
      sat_word = lo[WORD_W-1:0];
    end else begin
      sat_word = v[WORD_W-1:0];
    end
  endfunction

endpackage

`default_nettype wire

FILE: sv/ncs_ram.sv
// Generic simple dual-port RAM with registered read
`default_nettype none

module ncs_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // One write and one registered read per cycle
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

FILE: sv/ncs_dp.sv
// Datapath: knot, sweep and slope stores, shared multiplier, coefficient output
`default_nettype none

module ncs_dp #(
  parameter int MAX_KNOTS = 64,
  parameter int FRAC_BITS = 16
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire ncs_pkg::ncs_cmd_t             cmd,
  output ncs_pkg::ncs_sts_t                  sts,
  input  wire logic signed [ncs_pkg::WORD_W-1:0] in_knot_value,
  output logic                               out_valid,
  output logic signed [ncs_pkg::WORD_W-1:0]  out_coef_a,
  output logic signed [ncs_pkg::WORD_W-1:0]  out_coef_b,
  output logic signed [ncs_pkg::WORD_W-1:0]  out_coef_c,
  output logic signed [ncs_pkg::WORD_W-1:0]  out_coef_d,
  output logic                               out_last_segment
);

  import ncs_pkg::*;

  localparam int AW = $clog2(MAX_KNOTS);
  localparam int CW = $clog2(MAX_KNOTS + 1);

  // Rounded reciprocal 2^(2*FRAC_BITS) / den by long division (elaboration only)
  function automatic logic [63:0] recip_c(input logic [63:0] den);
    logic [63:0] num;
    logic [63:0] rem;
    logic [63:0] quo;
    num = (64'd1 << (2 * FRAC_BITS)) + (den >> 1);
    rem = '0;
    quo = '0;
    for (int b = 63; b >= 0; b--) begin
      rem = {rem[62:0], num[b]};
      if (rem >= den) begin
        rem    = rem - den;
        quo[b] = 1'b1;
      end
    end
    return quo;
  endfunction

  // Gamma table (interior) or the closing gamma for each predecessor
  function automatic gtab_t gamma_calc(input logic last_sel);
    gtab_t       tab;
    logic [63:0] g;
    logic [63:0] den;
    logic [63:0] q;
    g = 64'd1 << (FRAC_BITS - 1);
    for (int j = 0; j < GTAB_N; j++) begin
      if (j > 0) begin
        den = (64'd4 << FRAC_BITS) - g;
        g   = recip_c(den);
      end
      den    = (64'd2 << FRAC_BITS) - g;
      q      = recip_c(den);
      tab[j] = last_sel ? q[WORD_W-1:0] : g[WORD_W-1:0];
    end
    return tab;
  endfunction

  localparam gtab_t GAMMA_TAB = gamma_calc(1'b0);
  localparam gtab_t GLAST_TAB = gamma_calc(1'b1);
  localparam logic signed [63:0] HALF = 64'sd1 <<< (FRAC_BITS - 1);

  // Entries past the table end repeat its settled last entry
  function automatic logic [GIDX_W-1:0] tab_idx(input logic [AW-1:0] i);
    logic [AW+GIDX_W-1:0] w;
    w = {{GIDX_W{1'b0}}, i};
    if (w > (AW + GIDX_W)'(GTAB_N - 1)) begin
      tab_idx = GIDX_W'(GTAB_N - 1);
    end else begin
      tab_idx = w[GIDX_W-1:0];
    end
  endfunction

  logic [CW-1:0]            cnt_r;
  logic [AW-1:0]            n_r;
  logic [AW-1:0]            idx_r;
  logic signed [WORD_W-1:0] kl_r;
  logic signed [WORD_W-1:0] t_r;
  logic signed [63:0]       prod_r;
  logic signed [WORD_W-1:0] dprev_r;
  logic signed [WORD_W-1:0] dnext_r;
  logic signed [WORD_W-1:0] k0_r;
  logic signed [WORD_W-1:0] d0_r;
  logic [WORD_W-1:0]        glast_r;
  logic                     out_valid_r;

  logic                     full;
  logic                     k_we;
  logic [AW-1:0]            k_raddr;
  logic [AW-1:0]            la;
  logic [AW-1:0]            ra;
  logic [AW-1:0]            n_m1;
  logic [WORD_W-1:0]        k_rdata_u;
  logic [WORD_W-1:0]        s_rdata_u;
  logic [WORD_W-1:0]        sol_rdata_u;
  logic signed [WORD_W-1:0] k_rdata;
  logic signed [WORD_W-1:0] s_rdata;
  logic signed [WORD_W-1:0] sol_rdata;
  logic [WORD_W-1:0]        gain;
  logic signed [WORD_W-1:0] mul_a;
  logic signed [63:0]       rnd;
  logic signed [WORD_W-1:0] delta;
  logic signed [WORD_W-1:0] slope;
  logic signed [WORD_W-1:0] t_calc;
  logic signed [WORD_W-1:0] sol_wdata;
  logic [AW-1:0]            sol_waddr;
  logic signed [WORD_W-1:0] c_calc;
  logic signed [WORD_W-1:0] d_calc;
  logic signed [63:0]       dp_prev;

  assign full  = (cnt_r == CW'(MAX_KNOTS));
  assign k_we  = cmd.load && !full;
  assign n_m1  = n_r - AW'(1);
  assign k_rdata   = $signed(k_rdata_u);
  assign s_rdata   = $signed(s_rdata_u);
  assign sol_rdata = $signed(sol_rdata_u);

  // Status
  assign sts.cnt_nonzero    = (cnt_r != '0);
  assign sts.idx_zero       = (idx_r == '0);
  assign sts.idx_at_n       = (idx_r == n_r);
  assign sts.idx_at_seg_end = (idx_r == n_m1);

  // Knot read address per phase
  always_comb begin
    if (idx_r == '0) begin
      la = '0;
      ra = AW'(1);
    end else if (idx_r == n_r) begin
      la = n_m1;
      ra = n_r;
    end else begin
      la = idx_r - AW'(1);
      ra = idx_r + AW'(1);
    end
    if (cmd.sw_rd_l) begin
      k_raddr = la;
    end else if (cmd.sw_rd_r) begin
      k_raddr = ra;
    end else if (cmd.em_ld) begin
      k_raddr = AW'(1);
    end else if (cmd.em_out) begin
      k_raddr = idx_r + AW'(2);
    end else begin
      k_raddr = '0;
    end
  end

  // Shared multiplier operands
  always_comb begin
    if (cmd.bk_mul) begin
      mul_a = dnext_r;
      gain  = GAMMA_TAB[tab_idx(idx_r)];
    end else begin
      mul_a = t_r;
      gain  = (idx_r == n_r) ? glast_r : GAMMA_TAB[tab_idx(idx_r)];
    end
  end

  // Sweep term, rounding and saturation, slope and coefficient terms
  always_comb begin
    dp_prev   = (idx_r == '0) ? 64'sd0 : 64'(dprev_r);
    t_calc    = sat_word(64'sd3 * (64'(k_rdata) - 64'(kl_r)) - dp_prev);
    rnd       = (prod_r + HALF) >>> FRAC_BITS;
    delta     = sat_word(rnd);
    slope     = sat_word(64'(s_rdata) - rnd);
    sol_wdata = cmd.bk_init ? dprev_r : slope;
    sol_waddr = cmd.bk_init ? n_r : idx_r;
    c_calc    = sat_word(64'sd3 * (64'(k_rdata) - 64'(k0_r)) - 64'sd2 * 64'(d0_r)
                         - 64'(sol_rdata));
    d_calc    = sat_word(64'sd2 * (64'(k0_r) - 64'(k_rdata)) + 64'(d0_r)
                         + 64'(sol_rdata));
  end

  // Control registers: knot count, run length, index, closing gamma, output strobe
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r       <= '0;
      n_r         <= '0;
      idx_r       <= '0;
      glast_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cmd.close) begin
        cnt_r <= '0;
        n_r   <= full ? AW'(cnt_r - CW'(1)) : AW'(cnt_r);
      end else if (k_we) begin
        cnt_r <= cnt_r + CW'(1);
      end
      if (cmd.idx_clr) begin
        idx_r <= '0;
      end else if (cmd.bk_init) begin
        idx_r <= n_m1;
      end else if (cmd.idx_inc) begin
        idx_r <= idx_r + AW'(1);
      end else if (cmd.idx_dec) begin
        idx_r <= idx_r - AW'(1);
      end
      if (cmd.sw_rd_l) begin
        glast_r <= GLAST_TAB[tab_idx(n_m1)];
      end
      out_valid_r <= cmd.em_out;
    end
  end

  // Arithmetic and output registers
  always_ff @(posedge clk) begin
    if (cmd.sw_rd_r) begin
      kl_r <= k_rdata;
    end
    if (cmd.sw_diff) begin
      t_r <= t_calc;
    end
    if (cmd.sw_mul || cmd.bk_mul) begin
      prod_r <= mul_a * $signed(gain);
    end
    if (cmd.sw_wr) begin
      dprev_r <= delta;
    end
    if (cmd.bk_init) begin
      dnext_r <= dprev_r;
    end else if (cmd.bk_wr) begin
      dnext_r <= slope;
    end
    if (cmd.em_ld || cmd.em_out) begin
      k0_r <= k_rdata;
      d0_r <= sol_rdata;
    end
    if (cmd.em_out) begin
      out_coef_a       <= k0_r;
      out_coef_b       <= d0_r;
      out_coef_c       <= c_calc;
      out_coef_d       <= d_calc;
      out_last_segment <= (idx_r == n_m1);
    end
  end

  assign out_valid = out_valid_r;

  // Knot store
  ncs_ram #(.WIDTH(WORD_W), .DEPTH(MAX_KNOTS)) u_knot_ram (
    .clk   (clk),
    .we    (k_we),
    .waddr (cnt_r[AW-1:0]),
    .wdata (in_knot_value),
    .raddr (k_raddr),
    .rdata (k_rdata_u)
  );

  // Sweep store (delta values)
  ncs_ram #(.WIDTH(WORD_W), .DEPTH(MAX_KNOTS)) u_sweep_ram (
    .clk   (clk),
    .we    (cmd.sw_wr),
    .waddr (idx_r),
    .wdata (delta),
    .raddr (idx_r),
    .rdata (s_rdata_u)
  );

  // Slope store
  ncs_ram #(.WIDTH(WORD_W), .DEPTH(MAX_KNOTS)) u_sol_ram (
    .clk   (clk),
    .we    (cmd.bk_init || cmd.bk_wr),
    .waddr (sol_waddr),
    .wdata (sol_wdata),
    .raddr (k_raddr),
    .rdata (sol_rdata_u)
  );

endmodule

`default_nettype wire

FILE: sv/ncs_ctrl.sv
// Controller: sequences load, forward sweep, back substitution and emit
`default_nettype none

module ncs_ctrl (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              start,
  input  wire logic              last_knot,
  output logic                   busy,
  output ncs_pkg::ncs_cmd_t      cmd,
  input  wire ncs_pkg::ncs_sts_t sts
);

  import ncs_pkg::*;

  typedef enum logic [11:0] {
    ST_LOAD = 12'b0000_0000_0001,
    ST_SW_A = 12'b0000_0000_0010,
    ST_SW_B = 12'b0000_0000_0100,
    ST_SW_C = 12'b0000_0000_1000,
    ST_SW_M = 12'b0000_0001_0000,
    ST_SW_W = 12'b0000_0010_0000,
    ST_BK_I = 12'b0000_0100_0000,
    ST_BK_A = 12'b0000_1000_0000,
    ST_BK_B = 12'b0001_0000_0000,
    ST_EM_P = 12'b0010_0000_0000,
    ST_EM_L = 12'b0100_0000_0000,
    ST_EM_O = 12'b1000_0000_0000
  } state_t;

  state_t state_r;
  state_t state_nxt;

  assign busy = (state_r != ST_LOAD);

  // Next state and commands
  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    unique case (state_r)
      ST_LOAD: begin
        if (start) begin
          cmd.load = 1'b1;
          if (last_knot) begin
            cmd.close   = 1'b1;
            cmd.idx_clr = 1'b1;
            if (sts.cnt_nonzero) begin
              state_nxt = ST_SW_A;
            end
          end
        end
      end
      ST_SW_A: begin
        cmd.sw_rd_l = 1'b1;
        state_nxt   = ST_SW_B;
      end
      ST_SW_B: begin
        cmd.sw_rd_r = 1'b1;
        state_nxt   = ST_SW_C;
      end
      ST_SW_C: begin
        cmd.sw_diff = 1'b1;
        state_nxt   = ST_SW_M;
      end
      ST_SW_M: begin
        cmd.sw_mul = 1'b1;
        state_nxt  = ST_SW_W;
      end
      ST_SW_W: begin
        cmd.sw_wr = 1'b1;
        if (sts.idx_at_n) begin
          state_nxt = ST_BK_I;
        end else begin
          cmd.idx_inc = 1'b1;
          state_nxt   = ST_SW_A;
        end
      end
      ST_BK_I: begin
        cmd.bk_init = 1'b1;
        state_nxt   = ST_BK_A;
      end
      ST_BK_A: begin
        cmd.bk_mul = 1'b1;
        state_nxt  = ST_BK_B;
      end
      ST_BK_B: begin
        cmd.bk_wr = 1'b1;
        if (sts.idx_zero) begin
          state_nxt = ST_EM_P;
        end else begin
          cmd.idx_dec = 1'b1;
          state_nxt   = ST_BK_A;
        end
      end
      ST_EM_P: begin
        cmd.idx_clr = 1'b1;
        state_nxt   = ST_EM_L;
      end
      ST_EM_L: begin
        cmd.em_ld = 1'b1;
        state_nxt = ST_EM_O;
      end
      ST_EM_O: begin
        cmd.em_out = 1'b1;
        if (sts.idx_at_seg_end) begin
          state_nxt = ST_LOAD;
        end else begin
          cmd.idx_inc = 1'b1;
        end
      end
      default: begin
        state_nxt = ST_LOAD;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_LOAD;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Checks
  a_onehot: assert property (@(posedge clk) disable iff (!rst_n) $onehot(state_r))
    else $error("state register not one-hot");
  a_run_starts: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy && last_knot && sts.cnt_nonzero) |=> (state_r == ST_SW_A))
    else $error("closed run did not start the sweep");
  a_single_knot: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy && last_knot && !sts.cnt_nonzero) |=> !busy)
    else $error("single-knot run left the load state");
  a_back_done: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.bk_wr && sts.idx_zero) |=> (state_r == ST_EM_P))
    else $error("back substitution did not hand over to emit");

endmodule

`default_nettype wire

FILE: sv/natural_cubic_spline_fit.sv
// Top level: natural cubic spline fitter for one Q16.16 channel
//
// Usage: offer knots one word at a time on in_knot_value with start high;
// a word is taken at a clock edge where start is high and busy is low.
// While loading, busy stays low and one knot is taken every cycle that
// start is high. The word with in_last_knot high closes the run. Knots
// past MAX_KNOTS are dropped, though their last mark still closes the run.
// After the closing word busy goes high while the tridiagonal system is
// solved: the forward sweep takes each knot in turn through two reads on
// the knot store's one read port, difference, multiply and round; back
// substitution seeds the last slope, then multiplies and stores one slope
// per segment on the same multiplier; the emit is primed with the first
// knot and slope, then presents one segment per cycle. A run of one knot
// returns at once. Each result word is on out_coef_* for exactly one
// cycle with out_valid high; out_last_segment marks the final segment.
// The receiver cannot stall the output, so it must take every word as
// it appears. Reset (rst_n low, synchronous) empties the run and returns
// to loading; the stores need no clearing pass.
`default_nettype none

module natural_cubic_spline_fit #(
  parameter int MAX_KNOTS = 64,
  parameter int FRAC_BITS = 16
) (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  input  wire logic                              start,
  output logic                                   busy,
  input  wire logic signed [ncs_pkg::WORD_W-1:0] in_knot_value,
  input  wire logic                              in_last_knot,
  output logic                                   out_valid,
  output logic signed [ncs_pkg::WORD_W-1:0]      out_coef_a,
  output logic signed [ncs_pkg::WORD_W-1:0]      out_coef_b,
  output logic signed [ncs_pkg::WORD_W-1:0]      out_coef_c,
  output logic signed [ncs_pkg::WORD_W-1:0]      out_coef_d,
  output logic                                   out_last_segment
);

  import ncs_pkg::*;

  ncs_cmd_t cmd;
  ncs_sts_t sts;

  // Sequencer
  ncs_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .last_knot (in_last_knot),
    .busy      (busy),
    .cmd       (cmd),
    .sts       (sts)
  );

  // Stores and arithmetic
  ncs_dp #(.MAX_KNOTS(MAX_KNOTS), .FRAC_BITS(FRAC_BITS)) u_dp (
    .clk              (clk),
    .rst_n            (rst_n),
    .cmd              (cmd),
    .sts              (sts),
    .in_knot_value    (in_knot_value),
    .out_valid        (out_valid),
    .out_coef_a       (out_coef_a),
    .out_coef_b       (out_coef_b),
    .out_coef_c       (out_coef_c),
    .out_coef_d       (out_coef_d),
    .out_last_segment (out_last_segment)
  );

endmodule

`default_nettype wire

FILE: sim/testbench.sv
// Self-checking testbench for the natural cubic spline fitter
`timescale 1ns / 1ps

module testbench;

  localparam int KMAX = 64;
  localparam int FRAC = 16;
  localparam longint CYCLE_LIMIT = 400000;

  typedef struct {
    logic signed [31:0] a;
    logic signed [31:0] b;
    logic signed [31:0] c;
    logic signed [31:0] d;
    logic               last;
  } segment_t;

  logic clk;
  logic rst_n;
  logic start;
  logic busy;
  logic signed [31:0] in_knot_value;
  logic in_last_knot;
  logic out_valid;
  logic signed [31:0] out_coef_a, out_coef_b, out_coef_c, out_coef_d;
  logic out_last_segment;

  natural_cubic_spline_fit #(.MAX_KNOTS(KMAX), .FRAC_BITS(FRAC)) uut (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
    .in_knot_value(in_knot_value), .in_last_knot(in_last_knot),
    .out_valid(out_valid), .out_coef_a(out_coef_a), .out_coef_b(out_coef_b),
    .out_coef_c(out_coef_c), .out_coef_d(out_coef_d),
    .out_last_segment(out_last_segment)
  );

  // Predictor state
  logic signed [31:0] knots [KMAX];
  int unsigned        knots_held;
  longint unsigned    gammas [KMAX];
  segment_t           segments_due [$];
  int                 fail_count;
  longint             cycle_count;
  bit                 idle_gaps;

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // Run watchdog
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  function automatic longint sat32(input longint v);
    if (v > 64'sd2147483647) return 64'sd2147483647;
    if (v < -64'sd2147483648) return -64'sd2147483648;
    return v;
  endfunction

  function automatic longint unsigned reciprocal(input longint unsigned den);
    longint unsigned num;
    num = 64'd1 << (2 * FRAC);
    return (num + den / 2) / den;
  endfunction

  // Product by gamma, rounded half up (arithmetic shift floors)
  function automatic longint gamma_mul(input longint v, input longint unsigned g);
    longint p;
    p = v * longint'(g) + (64'sd1 <<< (FRAC - 1));
    return p >>> FRAC;
  endfunction

  task automatic init_gammas();
    gammas[0] = 64'd1 << (FRAC - 1);
    for (int i = 1; i < KMAX; i++) gammas[i] = reciprocal((64'd4 << FRAC) - gammas[i-1]);
  endtask

  // Thomas solve over held knots, queue the segment words
  task automatic solve_segments();
    longint delta [KMAX];
    longint slope [KMAX];
    longint t, k0, k1;
    longint unsigned glast;
    int n;
    segment_t s;
    n = int'(knots_held) - 1;
    knots_held = 0;
    if (n < 1) return;
    t = sat32(3 * (longint'(knots[1]) - knots[0]));
    delta[0] = sat32(gamma_mul(t, gammas[0]));
    for (int i = 1; i < n; i++) begin
      t = sat32(3 * (longint'(knots[i+1]) - knots[i-1]) - delta[i-1]);
      delta[i] = sat32(gamma_mul(t, gammas[i]));
    end
    glast = reciprocal((64'd2 << FRAC) - gammas[n-1]);
    t = sat32(3 * (longint'(knots[n]) - knots[n-1]) - delta[n-1]);
    delta[n] = sat32(gamma_mul(t, glast));
    slope[n] = delta[n];
    for (int i = n - 1; i >= 0; i--) slope[i] = sat32(delta[i] - gamma_mul(slope[i+1], gammas[i]));
    for (int i = 0; i < n; i++) begin
      k0 = knots[i];
      k1 = knots[i+1];
      s.a = k0[31:0];
      s.b = slope[i][31:0];
      t = sat32(3 * (k1 - k0) - 2 * slope[i] - slope[i+1]);
      s.c = t[31:0];
      t = sat32(2 * (k0 - k1) + slope[i] + slope[i+1]);
      s.d = t[31:0];
      s.last = (i == n - 1);
      segments_due.push_back(s);
    end
  endtask

  task automatic report(input string what, input logic [31:0] got, input logic [31:0] want);
    $display("mismatch %s: got %h want %h at %0t", what, got, want, $realtime);
    fail_count++;
  endtask

  // Result checker
  always @(posedge clk) begin
    segment_t s;
    if (rst_n && out_valid) begin
      if (segments_due.size() == 0) begin
        report("unexpected word", out_coef_a, 32'h0);
      end else begin
        s = segments_due.pop_front();
        if (out_coef_a !== s.a) report("coef_a", out_coef_a, s.a);
        if (out_coef_b !== s.b) report("coef_b", out_coef_b, s.b);
        if (out_coef_c !== s.c) report("coef_c", out_coef_c, s.c);
        if (out_coef_d !== s.d) report("coef_d", out_coef_d, s.d);
        if (out_last_segment !== s.last) report("last_segment", out_last_segment, s.last);
      end
    end
  end

  // Offer one knot word, wait for it to be taken; start stays high until
  // the next word or an idle gap replaces it
  task automatic send_knot(input logic [31:0] value, input bit last);
    int gap;
    if (idle_gaps && $urandom_range(0, 3) == 0) begin
      gap = $urandom_range(1, 12);
      start <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    start <= 1'b1;
    in_knot_value <= value;
    in_last_knot <= last;
    @(posedge clk);
    while (busy) @(posedge clk);
    if (knots_held < KMAX) begin
      knots[knots_held] = value;
      knots_held++;
    end
    if (last) solve_segments();
    @(negedge clk);
  endtask

  function automatic logic [31:0] rand_knot();
    case ($urandom_range(0, 4))
      0: return $urandom;
      1: return $urandom_range(0, 1) ? 32'h7FFF_FFFF : 32'h8000_0000;
      default: return 32'($signed($urandom_range(0, 32'h00A0_0000)) - 32'sh0050_0000);
    endcase
  endfunction

  task automatic send_run(input int len);
    for (int i = 0; i < len; i++) send_knot(rand_knot(), i == len - 1);
  endtask

  task automatic test_extremes();
    send_knot(32'h0000_0000, 1'b1);       // single knot: nothing out
    send_knot(32'h7FFF_FFFF, 1'b0);
    send_knot(32'h8000_0000, 1'b1);
    send_knot(32'h8000_0000, 1'b0);
    send_knot(32'h7FFF_FFFF, 1'b0);
    send_knot(32'h8000_0000, 1'b1);
    send_knot(32'h0001_0000, 1'b0);
    send_knot(32'hFFFF_FFFF, 1'b0);
    send_knot(32'h5555_5555, 1'b0);
    send_knot(32'hAAAA_AAAA, 1'b1);
  endtask

  task automatic test_overflow_run();
    // more knots than the store holds; closing mark on a dropped knot
    send_run(KMAX + 3);
    send_run(KMAX);
  endtask

  task automatic test_random_runs();
    int sent;
    sent = 0;
    while (sent < 160) begin
      int len;
      len = ($urandom_range(0, 9) == 0) ? $urandom_range(1, 2) : $urandom_range(3, 12);
      send_run(len);
      sent += len;
    end
  endtask

  task automatic test_back_to_back();
    idle_gaps = 0;
    for (int r = 0; r < 4; r++) send_run($urandom_range(2, 8));
  endtask

  initial begin
    rst_n = 1'b0;
    start = 1'b0;
    in_knot_value = '0;
    in_last_knot = 1'b0;
    fail_count = 0;
    cycle_count = 0;
    knots_held = 0;
    idle_gaps = 1;
    init_gammas();
    repeat (8) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);
    test_extremes();
    test_overflow_run();
    test_random_runs();
    test_back_to_back();
    start <= 1'b0;
    while (segments_due.size() != 0) @(negedge clk);
    repeat (600) @(negedge clk);
    if (fail_count == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

FILE: natural_cubic_spline_fit.f
sv/ncs_pkg.sv
sv/ncs_ram.sv
sv/ncs_dp.sv
sv/ncs_ctrl.sv
sv/natural_cubic_spline_fit.sv
sim/testbench.sv
